// ----- rtl/core/gdtp_pkg.sv -----
// ----------------------------------------------------------------------------
// Ground decal triangle projector package
// Shared types, register indexes, fixed-point constants and saturation.
// ----------------------------------------------------------------------------
package gdtp_pkg;

    // Default fraction bits of vertex and centre coordinates
    localparam int unsigned COORD_FRAC_BITS_DEF = 16;

    // Unit normal components are Q2.30
    localparam int unsigned UNIT_BITS = 30;

    // Up threshold 0.30 in Q2.30, lift 0.012 in Q0.30, 0.5 in Q16.16
    localparam logic [30:0] MIN_UP_Q30 = 31'd322122547;
    localparam logic [23:0] LIFT_Q30   = 24'd12884902;
    localparam int          HALF_Q16   = 32768;

    // Triangles held between the normal unit and the vertex pipeline
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN  = 3'd4;

    // Corner codes
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic        [1:0]  corner;
        logic               last_corner;
    } t_out;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_z;
        logic signed [15:0] forward_x;
        logic signed [15:0] forward_z;
        logic        [30:0] inv_span;
    } t_cfg;

    // Accepted triangle with its upward unit normal (Q2.30)
    typedef struct packed {
        t_in                vtx;
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
    } t_qitem;

    typedef struct packed {
        logic   push;
        t_qitem item;
    } t_qwr;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ground_decal_triangle_projector.sv -----
// ----------------------------------------------------------------------------
// Ground decal triangle projector
// Projects a top-down decal onto one receiver triangle: normal, rejection,
// lifted vertices with texture coordinates.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload            per transfer
//  -------   ----------------   ----------------   -----------------------
//  input     push / full        i_data  (t_in)     one triangle
//  result    pop / empty        o_data  (t_out)    one lifted corner
//  config    i_cfg_we           i_cfg_idx/wdata    one register write
//
//  The normal unit uses a bit-serial square root and divider, and the
//  range reduction shifts one bit a cycle. Accepted triangles leave
//  three corners, one after another, through a 7-stage vertex
//  pipeline, which holds while a result waits to be popped.
//  One triangle waits in the input buffer and two in the queue, so the
//  input side keeps taking work while results stall.
//  Reset is synchronous, active low; config registers return to defaults.
//
module ground_decal_triangle_projector #(
    parameter int unsigned COORD_FRAC_BITS = gdtp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  gdtp_pkg::t_in                    i_data,
    output logic                             empty,
    input  logic                             pop,
    output gdtp_pkg::t_out                   o_data,
    input  logic                             i_cfg_we,
    input  logic [gdtp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_wdata
);

    gdtp_pkg::t_cfg   r_cfg;
    gdtp_pkg::t_qwr   qwr;
    gdtp_pkg::t_qitem q_head;
    logic             q_full;
    logic             q_vld;
    logic             q_pop;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x  <= '0;
            r_cfg.center_z  <= '0;
            r_cfg.forward_x <= '0;
            r_cfg.forward_z <= 16'sd16384;
            r_cfg.inv_span  <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdtp_pkg::CFG_CENTER_X:  r_cfg.center_x  <= i_cfg_wdata;
                gdtp_pkg::CFG_CENTER_Z:  r_cfg.center_z  <= i_cfg_wdata;
                gdtp_pkg::CFG_FORWARD_X: r_cfg.forward_x <= i_cfg_wdata[15:0];
                gdtp_pkg::CFG_FORWARD_Z: r_cfg.forward_z <= i_cfg_wdata[15:0];
                gdtp_pkg::CFG_INV_SPAN:  r_cfg.inv_span  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Normal unit: classify and drop degenerate or steep triangles
    gdtp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (i_data),
        .o_full   (full),
        .i_q_full (q_full),
        .o_qwr    (qwr)
    );

    // Hold accepted triangles so both sides stall independently
    gdtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_vld   (q_vld)
    );

    // Vertex pipeline: one corner per transfer
    gdtp_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (q_head),
        .i_head_vld (q_vld),
        .o_head_pop (q_pop),
        .o_data     (o_data),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule

// ----- rtl/core/gdtp_front.sv -----
// ----------------------------------------------------------------------------
// Ground decal normal unit
// Takes triangles, finds the unit face normal bit-serially and drops
// degenerate or steep ones; accepted triangles go to the queue.
// ----------------------------------------------------------------------------
module gdtp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gdtp_pkg::t_in   i_data,
    output logic            o_full,
    input  logic            i_q_full,
    output gdtp_pkg::t_qwr  o_qwr
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_EDGE  = 12'b000000000010,
        ST_MAGE  = 12'b000000000100,
        ST_REDE  = 12'b000000001000,
        ST_MUL   = 12'b000000010000,
        ST_CROSS = 12'b000000100000,
        ST_MAGN  = 12'b000001000000,
        ST_REDN  = 12'b000010000000,
        ST_SQ    = 12'b000100000000,
        ST_SUM   = 12'b001000000000,
        ST_SQRT  = 12'b010000000000,
        ST_DIV   = 12'b100000000000
    } t_fstate;

    localparam int unsigned STEPS = gdtp_pkg::UNIT_BITS + 1;

    logic                r_ibuf_vld;
    gdtp_pkg::t_in       r_ibuf;
    gdtp_pkg::t_in       r_vtx;
    t_fstate             r_state;
    logic                r_div_init;
    logic                r_push_st;
    logic signed [32:0]  r_e    [6];
    logic        [61:0]  r_m;
    logic signed [61:0]  r_prod [6];
    logic signed [62:0]  r_n    [3];
    logic        [60:0]  r_sq   [3];
    logic        [61:0]  r_x;
    logic        [61:0]  r_r;
    logic        [61:0]  r_bit;
    logic        [4:0]   r_cnt;
    logic        [30:0]  r_len;
    logic        [31:0]  r_rem  [3];
    logic        [30:0]  r_dvd  [3];
    logic        [30:0]  r_q    [3];
    logic        [2:0]   r_neg;

    logic        [61:0]  or_e;
    logic        [61:0]  or_n;
    logic        [30:0]  nmag [3];
    logic        [62:0]  sq_t;
    logic                sq_ge;
    logic                flip;
    logic                up_ok;
    logic signed [31:0]  unit [3];
    logic                take;

    assign o_full = r_ibuf_vld;
    assign take   = (r_state == ST_IDLE) && r_ibuf_vld && !r_div_init && !r_push_st;

    always_comb begin
        logic [32:0] em;
        logic [62:0] nm;
        or_e = '0;
        or_n = '0;
        for (int i = 0; i < 6; i++) begin
            em   = r_e[i][32] ? 33'(-r_e[i]) : 33'(r_e[i]);
            or_e = or_e | 62'(em);
        end
        for (int i = 0; i < 3; i++) begin
            nm      = r_n[i][62] ? 63'(-r_n[i]) : 63'(r_n[i]);
            or_n    = or_n | nm[61:0];
            nmag[i] = nm[30:0];
        end
        sq_t  = {1'b0, r_r} + {1'b0, r_bit};
        sq_ge = {1'b0, r_x} >= sq_t;
        flip  = r_neg[1] && (r_q[1] != '0);
        up_ok = r_q[1] >= gdtp_pkg::MIN_UP_Q30;
        for (int i = 0; i < 3; i++) begin
            unit[i] = (r_neg[i] ^ flip) ? -$signed({1'b0, r_q[i]}) : $signed({1'b0, r_q[i]});
        end
        o_qwr.push        = r_push_st && up_ok && !i_q_full;
        o_qwr.item.vtx    = r_vtx;
        o_qwr.item.unit_x = unit[0];
        o_qwr.item.unit_y = unit[1];
        o_qwr.item.unit_z = unit[2];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ibuf_vld <= 1'b0;
            r_state    <= ST_IDLE;
            r_div_init <= 1'b0;
            r_push_st  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_push && !r_ibuf_vld) begin
                r_ibuf_vld <= 1'b1;
            end else if (take) begin
                r_ibuf_vld <= 1'b0;
            end
            r_div_init <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (r_push_st) begin
                        if (!up_ok || !i_q_full) begin
                            r_push_st <= 1'b0;
                        end
                    end else if (take) begin
                        r_state <= ST_EDGE;
                    end
                end
                ST_EDGE:  r_state <= ST_MAGE;
                ST_MAGE:  r_state <= ST_REDE;
                ST_REDE: begin
                    if (r_m[61:30] == '0) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:   r_state <= ST_CROSS;
                ST_CROSS: r_state <= ST_MAGN;
                ST_MAGN:  r_state <= ST_REDN;
                ST_REDN: begin
                    if (r_m[61:30] == '0) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ:    r_state <= ST_SUM;
                ST_SUM: begin
                    r_cnt <= '0;
                    // drop a degenerate triangle
                    if (r_sq[0] == '0 && r_sq[1] == '0 && r_sq[2] == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == 5'(STEPS - 1)) begin
                        r_cnt      <= '0;
                        r_div_init <= 1'b1;
                        r_state    <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_DIV: begin
                    if (!r_div_init) begin
                        if (r_cnt == 5'(STEPS - 1)) begin
                            r_cnt     <= '0;
                            r_push_st <= 1'b1;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_push && !r_ibuf_vld) begin
            r_ibuf <= i_data;
        end
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    r_vtx <= r_ibuf;
                end
            end
            ST_EDGE: begin
                r_e[0] <= 33'(r_vtx.b_x) - 33'(r_vtx.a_x);
                r_e[1] <= 33'(r_vtx.b_y) - 33'(r_vtx.a_y);
                r_e[2] <= 33'(r_vtx.b_z) - 33'(r_vtx.a_z);
                r_e[3] <= 33'(r_vtx.c_x) - 33'(r_vtx.a_x);
                r_e[4] <= 33'(r_vtx.c_y) - 33'(r_vtx.a_y);
                r_e[5] <= 33'(r_vtx.c_z) - 33'(r_vtx.a_z);
            end
            ST_MAGE: r_m <= or_e;
            ST_REDE: begin
                // shift all edges together until every magnitude is below 2^30
                if (r_m[61:30] != '0) begin
                    r_m <= r_m >> 1;
                    for (int i = 0; i < 6; i++) begin
                        r_e[i] <= r_e[i] >>> 1;
                    end
                end
            end
            ST_MUL: begin
                r_prod[0] <= 62'($signed(r_e[1][30:0])) * 62'($signed(r_e[5][30:0]));
                r_prod[1] <= 62'($signed(r_e[2][30:0])) * 62'($signed(r_e[4][30:0]));
                r_prod[2] <= 62'($signed(r_e[2][30:0])) * 62'($signed(r_e[3][30:0]));
                r_prod[3] <= 62'($signed(r_e[0][30:0])) * 62'($signed(r_e[5][30:0]));
                r_prod[4] <= 62'($signed(r_e[0][30:0])) * 62'($signed(r_e[4][30:0]));
                r_prod[5] <= 62'($signed(r_e[1][30:0])) * 62'($signed(r_e[3][30:0]));
            end
            ST_CROSS: begin
                r_n[0] <= 63'(r_prod[0]) - 63'(r_prod[1]);
                r_n[1] <= 63'(r_prod[2]) - 63'(r_prod[3]);
                r_n[2] <= 63'(r_prod[4]) - 63'(r_prod[5]);
            end
            ST_MAGN: r_m <= or_n;
            ST_REDN: begin
                if (r_m[61:30] != '0) begin
                    r_m <= r_m >> 1;
                    for (int i = 0; i < 3; i++) begin
                        r_n[i] <= r_n[i] >>> 1;
                    end
                end
            end
            ST_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i]  <= 61'(62'(nmag[i]) * 62'(nmag[i]));
                    r_neg[i] <= r_n[i][62];
                end
            end
            ST_SUM: begin
                r_x   <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
                r_r   <= '0;
                r_bit <= 62'd1 << (2 * gdtp_pkg::UNIT_BITS);
            end
            ST_SQRT: begin
                // one root bit per cycle
                if (sq_ge) begin
                    r_x <= r_x - sq_t[61:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIV: begin
                if (r_div_init) begin
                    r_len <= r_r[30:0];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= 32'(nmag[i][30:1]);
                        r_dvd[i] <= {nmag[i][0], 30'd0};
                        r_q[i]   <= '0;
                    end
                end else begin
                    // one quotient bit per cycle in each lane
                    for (int i = 0; i < 3; i++) begin
                        if ({r_rem[i], r_dvd[i][30]} >= 33'(r_len)) begin
                            r_rem[i] <= 32'({r_rem[i], r_dvd[i][30]} - 33'(r_len));
                            r_q[i]   <= {r_q[i][29:0], 1'b1};
                        end else begin
                            r_rem[i] <= {r_rem[i][30:0], r_dvd[i][30]};
                            r_q[i]   <= {r_q[i][29:0], 1'b0};
                        end
                        r_dvd[i] <= {r_dvd[i][29:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_div_init) |-> r_len != '0)
        else $error("divider runs with zero length");

    a_push_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qwr.push |-> (o_qwr.item.unit_y >= $signed({1'b0, gdtp_pkg::MIN_UP_Q30})))
        else $error("steep triangle pushed");

endmodule

// ----- rtl/core/gdtp_queue.sv -----
// ----------------------------------------------------------------------------
// Ground decal triangle queue
// Short first-in first-out store between the normal unit and vertex pipeline.
// ----------------------------------------------------------------------------
module gdtp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdtp_pkg::t_qwr    i_qwr,
    output logic              o_full,
    input  logic              i_pop,
    output gdtp_pkg::t_qitem  o_head,
    output logic              o_vld
);

    localparam int unsigned DEPTH = gdtp_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    gdtp_pkg::t_qitem r_slot [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr;
    logic             rd;

    assign o_full = r_cnt == CW'(DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_head = r_slot[r_rp];
    assign wr     = i_qwr.push && !o_full;
    assign rd     = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wp] <= i_qwr.item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_qwr.push && o_full))
        else $error("push into full triangle queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_vld))
        else $error("pop from empty triangle queue");

endmodule

// ----- rtl/core/gdtp_back.sv -----
// ----------------------------------------------------------------------------
// Ground decal vertex pipeline
// Lifts each corner along the normal and computes its texture coordinates.
// ----------------------------------------------------------------------------
module gdtp_back #(
    parameter int unsigned COORD_FRAC_BITS = gdtp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdtp_pkg::t_cfg    i_cfg,
    input  gdtp_pkg::t_qitem  i_head,
    input  logic              i_head_vld,
    output logic              o_head_pop,
    output gdtp_pkg::t_out    o_data,
    output logic              o_empty,
    input  logic              i_pop
);

    localparam int unsigned LIFT_SH = 2 * gdtp_pkg::UNIT_BITS - COORD_FRAC_BITS;
    localparam int unsigned TEX_SH  = COORD_FRAC_BITS + 14;
    localparam logic signed [56:0] LIFT_S    = 57'(gdtp_pkg::LIFT_Q30);
    localparam logic signed [56:0] LIFT_HALF = 57'sd1 <<< (LIFT_SH - 1);

    logic [6:0]          r_vld;
    logic [1:0]          r_k;
    logic                en;

    logic [1:0]          r1_k;
    logic signed [31:0]  r1_p   [3];
    logic signed [32:0]  r1_dx;
    logic signed [32:0]  r1_dz;
    logic signed [56:0]  r1_prod[3];

    logic [1:0]          r2_k;
    logic signed [31:0]  r2_o   [3];
    logic signed [48:0]  r2_mu  [4];

    logic [1:0]          r3_k;
    logic signed [31:0]  r3_o   [3];
    logic signed [49:0]  r3_t   [2];

    logic [1:0]          r4_k;
    logic signed [31:0]  r4_o   [3];
    logic [1:0]          r4_neg;
    logic [49:0]         r4_a   [2];

    logic [1:0]          r5_k;
    logic signed [31:0]  r5_o   [3];
    logic [1:0]          r5_neg;
    logic [55:0]         r5_lo  [2];
    logic [55:0]         r5_hi  [2];

    logic [1:0]          r6_k;
    logic signed [31:0]  r6_o   [3];
    logic [1:0]          r6_neg;
    logic [58:0]         r6_res [2];

    gdtp_pkg::t_out      r_out;

    logic signed [31:0]  vsel [3];
    logic signed [31:0]  usel [3];

    // Whole pipeline advances while the output register can move
    assign en         = !r_vld[6] || i_pop;
    assign o_head_pop = en && i_head_vld && (r_k == gdtp_pkg::CORNER_C);
    assign o_empty    = !r_vld[6];
    assign o_data     = r_out;

    always_comb begin
        case (r_k)
            gdtp_pkg::CORNER_A: begin
                vsel[0] = i_head.vtx.a_x;
                vsel[1] = i_head.vtx.a_y;
                vsel[2] = i_head.vtx.a_z;
            end
            gdtp_pkg::CORNER_B: begin
                vsel[0] = i_head.vtx.b_x;
                vsel[1] = i_head.vtx.b_y;
                vsel[2] = i_head.vtx.b_z;
            end
            default: begin
                vsel[0] = i_head.vtx.c_x;
                vsel[1] = i_head.vtx.c_y;
                vsel[2] = i_head.vtx.c_z;
            end
        endcase
        usel[0] = i_head.unit_x;
        usel[1] = i_head.unit_y;
        usel[2] = i_head.unit_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_k   <= gdtp_pkg::CORNER_A;
        end else if (en) begin
            r_vld <= {r_vld[5:0], i_head_vld};
            if (i_head_vld) begin
                r_k <= (r_k == gdtp_pkg::CORNER_C) ? gdtp_pkg::CORNER_A : r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [56:0] off;
        logic signed [59:0] q;
        if (en) begin
            // corner select, centre offset, lift product
            r1_k  <= r_k;
            r1_dx <= 33'(vsel[0]) - 33'(i_cfg.center_x);
            r1_dz <= 33'(vsel[2]) - 33'(i_cfg.center_z);
            for (int i = 0; i < 3; i++) begin
                r1_p[i]    <= vsel[i];
                r1_prod[i] <= 57'(usel[i]) * LIFT_S;
            end
            // round the lift, add and saturate; axis products
            r2_k <= r1_k;
            for (int i = 0; i < 3; i++) begin
                off     = (r1_prod[i] + LIFT_HALF) >>> LIFT_SH;
                r2_o[i] <= gdtp_pkg::sat32(64'(r1_p[i]) + 64'(off));
            end
            r2_mu[0] <= 49'(r1_dx) * 49'(i_cfg.forward_z);
            r2_mu[1] <= 49'(r1_dz) * 49'(i_cfg.forward_x);
            r2_mu[2] <= 49'(r1_dx) * 49'(i_cfg.forward_x);
            r2_mu[3] <= 49'(r1_dz) * 49'(i_cfg.forward_z);
            // dot products along the left and forward axes
            r3_k    <= r2_k;
            r3_o    <= r2_o;
            r3_t[0] <= 50'(r2_mu[0]) - 50'(r2_mu[1]);
            r3_t[1] <= 50'(r2_mu[2]) + 50'(r2_mu[3]);
            // sign and magnitude
            r4_k <= r3_k;
            r4_o <= r3_o;
            for (int i = 0; i < 2; i++) begin
                r4_neg[i] <= r3_t[i][49];
                r4_a[i]   <= r3_t[i][49] ? 50'(-r3_t[i]) : 50'(r3_t[i]);
            end
            // scale by the inverse span in two partial products
            r5_k   <= r4_k;
            r5_o   <= r4_o;
            r5_neg <= r4_neg;
            for (int i = 0; i < 2; i++) begin
                r5_lo[i] <= 56'(r4_a[i][24:0]) * 56'(i_cfg.inv_span);
                r5_hi[i] <= 56'(r4_a[i][49:25]) * 56'(i_cfg.inv_span);
            end
            // combine and drop fraction bits
            r6_k   <= r5_k;
            r6_o   <= r5_o;
            r6_neg <= r5_neg;
            for (int i = 0; i < 2; i++) begin
                r6_res[i] <= 59'(((81'(r5_hi[i]) << 25) + 81'(r5_lo[i])) >> TEX_SH);
            end
            // restore sign, center at 0.5, saturate
            r_out.out_x       <= r6_o[0];
            r_out.out_y       <= r6_o[1];
            r_out.out_z       <= r6_o[2];
            r_out.corner      <= r6_k;
            r_out.last_corner <= r6_k == gdtp_pkg::CORNER_C;
            q           = r6_neg[0] ? -$signed({1'b0, r6_res[0]}) : $signed({1'b0, r6_res[0]});
            r_out.tex_u <= gdtp_pkg::sat32(64'(q) + 64'(gdtp_pkg::HALF_Q16));
            q           = r6_neg[1] ? -$signed({1'b0, r6_res[1]}) : $signed({1'b0, r6_res[1]});
            r_out.tex_v <= gdtp_pkg::sat32(64'(q) + 64'(gdtp_pkg::HALF_Q16));
        end
    end

    a_corner_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k == gdtp_pkg::CORNER_A || r_k == gdtp_pkg::CORNER_B || r_k == gdtp_pkg::CORNER_C)
        else $error("corner counter out of range");

endmodule
